// ===== sv/ptsb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsb_pkg
// Types and constants of the periodic timer slot bank: command and reply
// codes, register indexes, reset values and the layout of one slot entry.
// ----------------------------------------------------------------------------
package ptsb_pkg;

	localparam logic [2:0] CMD_CREATE  = 3'd0;
	localparam logic [2:0] CMD_KILL    = 3'd1;
	localparam logic [2:0] CMD_TICK    = 3'd2;
	localparam logic [2:0] CMD_ENABLE  = 3'd3;
	localparam logic [2:0] CMD_DISABLE = 3'd4;
	localparam logic [2:0] CMD_UPTIME  = 3'd5;

	localparam logic [1:0] KIND_CREATE = 2'd0;
	localparam logic [1:0] KIND_KILL   = 2'd1;
	localparam logic [1:0] KIND_FIRED  = 2'd2;
	localparam logic [1:0] KIND_ACK    = 2'd3;

	localparam logic REG_TICK_PERIOD = 1'b0;
	localparam logic REG_UPTIME_STEP = 1'b1;

	localparam int CFG_W    = 20;
	localparam int PERIOD_W = 20;
	localparam int STEP_W   = 10;
	localparam int RELOAD_W = 27;
	localparam int CD_W     = 28;

	localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 20'd54925;
	localparam logic [STEP_W-1:0]   UPTIME_STEP_RST = 10'd54;
	localparam logic [9:0]          MS_TO_US        = 10'd1000;

	// Only this many fired beats are reported per tick.
	localparam logic [3:0] MAX_RES = 4'd8;

	typedef struct packed {
		logic [31:0]               handler;
		logic [RELOAD_W-1:0]       reload;
		logic signed [CD_W-1:0]    countdown;
	} slot_entry_t;

endpackage

// ===== sv/periodic_timer_slot_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_slot_bank
// Bank of periodic timer slots. Slot contents live in a one-port-read,
// one-port-write synchronous memory; occupancy is held in flip-flops.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  command   | start, busy (out)          | cmd, rate_ms, handler_tag, timer_id
//  result    | result_valid (one cycle)   | kind, slot_number, fired_handler,
//            |                            | ok, uptime_ms, last
//  config    | cfg_we                     | cfg_index, cfg_data
//
//  A command is taken when start is high and busy is low. Create, kill,
//  enable, disable, uptime and disabled-tick commands give their single
//  beat from the execute state. Other ticks walk the slot memory one entry
//  per cycle through its single read port and one subtractor, then flush;
//  their fired beats may come back to back. Reset clears all slots at once
//  through the occupancy flags. The receiver cannot stall the result beats.
//
module periodic_timer_slot_bank #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                cmd,
	input  logic [15:0]               rate_ms,
	input  logic [31:0]               handler_tag,
	input  logic [15:0]               timer_id,
	output logic                      result_valid,
	output logic [1:0]                kind,
	output logic [3:0]                slot_number,
	output logic [31:0]               fired_handler,
	output logic                      ok,
	output logic [31:0]               uptime_ms,
	output logic                      last,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [ptsb_pkg::CFG_W-1:0] cfg_data
);
	import ptsb_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]            state_q;
	logic [2:0]            cmd_q;
	logic [15:0]           rate_q;
	logic [31:0]           tag_q;
	logic [15:0]           id_q;
	logic [PERIOD_W-1:0]   tick_period_q;
	logic [STEP_W-1:0]     step_q;
	logic                  disabled_q;
	logic [31:0]           uptime_q;
	logic [NUM_SLOTS-1:0]  used_q;
	logic [IW-1:0]         idx_q;
	logic [3:0]            fire_cnt_q;
	logic                  pend_valid_q;
	logic [3:0]            pend_slot_q;
	logic [31:0]           pend_handler_q;

	logic                  res_valid_q;
	logic [1:0]            kind_q;
	logic [3:0]            slot_q;
	logic [31:0]           handler_q;
	logic                  ok_q;
	logic                  last_q;

	slot_entry_t           mem [NUM_SLOTS];
	slot_entry_t           rd_q;
	slot_entry_t           wdata;
	logic                  we;
	logic [IW-1:0]         waddr;
	logic [IW-1:0]         raddr;

	// Lowest free slot.
	logic                  free_found;
	logic [IW-1:0]         free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	logic [25:0]           prod;
	logic [25:0]           period;
	logic                  create_ok;
	logic [5:0]            create_num;
	assign prod       = rate_q * MS_TO_US;
	assign period     = (prod < {6'd0, tick_period_q}) ? {6'd0, tick_period_q} : prod;
	assign create_ok  = (tag_q != 32'd0) && free_found;
	assign create_num = 6'(free_idx) + 6'd1;

	logic [15:0]           id_m1;
	logic                  kill_ok;
	assign id_m1   = id_q - 16'd1;
	assign kill_ok = (id_q != 16'd0) && (id_q <= 16'(NUM_SLOTS)) && used_q[id_m1[IW-1:0]];

	// Countdown update of the slot under the walk.
	logic signed [29:0]    cd_sub;
	logic signed [29:0]    cd_add;
	logic signed [CD_W-1:0] cd_new;
	logic                  fire;
	logic                  walk_used;
	logic [5:0]            walk_num;
	assign cd_sub    = 30'(rd_q.countdown) - $signed({10'd0, tick_period_q});
	assign fire      = cd_sub[29] || (cd_sub == 30'sd0);
	assign cd_add    = cd_sub + $signed({3'd0, rd_q.reload});
	assign walk_used = used_q[idx_q];
	assign walk_num  = 6'(idx_q) + 6'd1;
	always_comb begin
		if (!fire) begin
			cd_new = cd_sub[CD_W-1:0];
		end else if (cd_add < -(30'sd1 <<< (CD_W - 1))) begin
			cd_new = {1'b1, {(CD_W-1){1'b0}}};
		end else begin
			cd_new = cd_add[CD_W-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rd_q;
		if (state_q == ST_EXEC && cmd_q == CMD_CREATE && create_ok) begin
			we             = 1'b1;
			waddr          = free_idx;
			wdata.handler  = tag_q;
			wdata.reload   = RELOAD_W'(period);
			wdata.countdown = CD_W'(period);
		end else if (state_q == ST_WALK && walk_used) begin
			we              = 1'b1;
			wdata.countdown = cd_new;
		end
	end

	assign raddr = (state_q == ST_WALK && idx_q != LAST_IDX) ? idx_q + IW'(1) : '0;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cmd_q          <= CMD_UPTIME;
			rate_q         <= '0;
			tag_q          <= '0;
			id_q           <= '0;
			tick_period_q  <= TICK_PERIOD_RST;
			step_q         <= UPTIME_STEP_RST;
			disabled_q     <= 1'b0;
			uptime_q       <= '0;
			used_q         <= '0;
			idx_q          <= '0;
			fire_cnt_q     <= '0;
			pend_valid_q   <= 1'b0;
			pend_slot_q    <= '0;
			pend_handler_q <= '0;
			res_valid_q    <= 1'b0;
			kind_q         <= KIND_ACK;
			slot_q         <= '0;
			handler_q      <= '0;
			ok_q           <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_TICK_PERIOD: tick_period_q <= cfg_data;
					REG_UPTIME_STEP: step_q <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						rate_q  <= rate_ms;
						tag_q   <= handler_tag;
						id_q    <= timer_id;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b1;
					kind_q      <= KIND_ACK;
					slot_q      <= '0;
					handler_q   <= '0;
					ok_q        <= 1'b0;
					last_q      <= 1'b1;
					case (cmd_q)
						CMD_CREATE: begin
							kind_q <= KIND_CREATE;
							if (create_ok) begin
								used_q[free_idx] <= 1'b1;
								slot_q <= create_num[3:0];
								ok_q   <= 1'b1;
							end
						end
						CMD_KILL: begin
							kind_q <= KIND_KILL;
							if (kill_ok) begin
								used_q[id_m1[IW-1:0]] <= 1'b0;
								slot_q <= id_q[3:0];
								ok_q   <= 1'b1;
							end
						end
						CMD_TICK: begin
							if (!disabled_q) begin
								// The walk reports its own beats.
								res_valid_q  <= 1'b0;
								uptime_q     <= uptime_q + 32'(step_q);
								idx_q        <= '0;
								fire_cnt_q   <= '0;
								pend_valid_q <= 1'b0;
								state_q      <= ST_WALK;
							end
						end
						CMD_ENABLE:  disabled_q <= 1'b0;
						CMD_DISABLE: disabled_q <= 1'b1;
						default: ;
					endcase
				end
				ST_WALK: begin
					// A fired slot is held back one beat so that the final one can carry last.
					if (walk_used && fire && fire_cnt_q < MAX_RES) begin
						if (pend_valid_q) begin
							res_valid_q <= 1'b1;
							kind_q      <= KIND_FIRED;
							slot_q      <= pend_slot_q;
							handler_q   <= pend_handler_q;
							ok_q        <= 1'b0;
							last_q      <= 1'b0;
						end
						pend_valid_q   <= 1'b1;
						pend_slot_q    <= walk_num[3:0];
						pend_handler_q <= rd_q.handler;
						fire_cnt_q     <= fire_cnt_q + 4'd1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_FLUSH: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b1;
					ok_q        <= 1'b0;
					last_q      <= 1'b1;
					if (pend_valid_q) begin
						kind_q    <= KIND_FIRED;
						slot_q    <= pend_slot_q;
						handler_q <= pend_handler_q;
					end else begin
						kind_q    <= KIND_ACK;
						slot_q    <= '0;
						handler_q <= '0;
					end
					pend_valid_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_valid  = res_valid_q;
	assign kind          = kind_q;
	assign slot_number   = slot_q;
	assign fired_handler = handler_q;
	assign ok            = ok_q;
	assign uptime_ms     = uptime_q;
	assign last          = last_q;

	a_fired_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && kind_q == KIND_FIRED |-> slot_q != 4'd0 && !ok_q)
		else $error("fired beat without a slot number");

	a_ok_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && ok_q |-> slot_q != 4'd0 && (kind_q == KIND_CREATE || kind_q == KIND_KILL))
		else $error("successful reply without a slot number");

	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |=> res_valid_q && last_q && state_q == ST_IDLE)
		else $error("tick walk did not end with a final beat");

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= MAX_RES)
		else $error("too many fired beats in one tick");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !res_valid_q)
		else $error("accepted command did not raise busy");

endmodule

// ===== verif/periodic_timer_slot_bank_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_slot_bank_checker
// Watches the command, configuration and result ports of the timer slot bank.
// It keeps its own copy of the slots, the uptime and the two registers. It
// also works out the beats that each accepted command should produce. Each
// result beat is compared field by field with the oldest expected beat.
// ----------------------------------------------------------------------------
module periodic_timer_slot_bank_checker #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [2:0]                 cmd,
	input  logic [15:0]                rate_ms,
	input  logic [31:0]                handler_tag,
	input  logic [15:0]                timer_id,
	input  logic                       result_valid,
	input  logic [1:0]                 kind,
	input  logic [3:0]                 slot_number,
	input  logic [31:0]                fired_handler,
	input  logic                       ok,
	input  logic [31:0]                uptime_ms,
	input  logic                       last,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ptsb_pkg::CFG_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         beats_pending
);
	import ptsb_pkg::*;

	localparam longint CD_FLOOR = -(longint'(1) << (CD_W - 1));

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  slot_number;
		logic [31:0] fired_handler;
		logic        ok;
		logic [31:0] uptime_ms;
		logic        last;
	} timer_beat_t;

	timer_beat_t         expected_beats[$];
	logic [31:0]         handler_of[NUM_SLOTS];
	logic [31:0]         reload_of[NUM_SLOTS];
	int                  countdown_of[NUM_SLOTS];
	logic                ticks_off;
	logic [31:0]         uptime_now;
	logic [PERIOD_W-1:0] tick_us;
	logic [STEP_W-1:0]   step_ms;
	int                  failures = 0;
	int                  queued = 0;

	assign fail_count = failures;
	assign beats_pending = queued;

	function automatic timer_beat_t make_beat(logic [1:0] beat_kind, logic [3:0] slot,
			logic [31:0] handler, logic succeeded);
		timer_beat_t b;
		b.kind = beat_kind;
		b.slot_number = slot;
		b.fired_handler = handler;
		b.ok = succeeded;
		b.uptime_ms = uptime_now;
		b.last = 1'b0;
		return b;
	endfunction

	// Applies one command to the slot copy and queues the beats it should give.
	task automatic run_timer_command(input logic [2:0] code, input logic [15:0] rate,
			input logic [31:0] tag, input logic [15:0] id);
		timer_beat_t beats[$];
		logic [31:0] period;
		logic [3:0]  slot;
		longint      next_cd;
		case (code)
			CMD_CREATE: begin
				slot = '0;
				period = 32'(rate) * 32'(MS_TO_US);
				if (period < 32'(tick_us)) begin
					period = 32'(tick_us);
				end
				if (tag != '0) begin
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (slot == '0 && handler_of[i] == '0) begin
							handler_of[i] = tag;
							reload_of[i] = period;
							countdown_of[i] = int'(period);
							slot = 4'(i + 1);
						end
					end
				end
				beats.push_back(make_beat(KIND_CREATE, slot, '0, slot != '0));
			end
			CMD_KILL: begin
				if (id >= 1 && id <= NUM_SLOTS && handler_of[id - 1] != '0) begin
					handler_of[id - 1] = '0;
					beats.push_back(make_beat(KIND_KILL, 4'(id), '0, 1'b1));
				end else begin
					beats.push_back(make_beat(KIND_KILL, '0, '0, 1'b0));
				end
			end
			CMD_TICK: begin
				if (!ticks_off) begin
					uptime_now = uptime_now + 32'(step_ms);
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (handler_of[i] != '0) begin
							next_cd = longint'(countdown_of[i]) - longint'(tick_us);
							if (next_cd <= 0) begin
								next_cd += longint'(reload_of[i]);
								// A period shorter than the tick keeps pulling the count down.
								if (next_cd < CD_FLOOR) begin
									next_cd = CD_FLOOR;
								end
								if (beats.size() < MAX_RES) begin
									beats.push_back(make_beat(KIND_FIRED, 4'(i + 1),
										handler_of[i], 1'b0));
								end
							end
							countdown_of[i] = int'(next_cd);
						end
					end
				end
				if (beats.size() == 0) begin
					beats.push_back(make_beat(KIND_ACK, '0, '0, 1'b0));
				end
			end
			default: begin
				if (code == CMD_ENABLE) begin
					ticks_off = 1'b0;
				end else if (code == CMD_DISABLE) begin
					ticks_off = 1'b1;
				end
				beats.push_back(make_beat(KIND_ACK, '0, '0, 1'b0));
			end
		endcase
		beats[beats.size() - 1].last = 1'b1;
		foreach (beats[i]) begin
			expected_beats.push_back(beats[i]);
		end
	endtask

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_beat_t want;
		int          bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				handler_of[i] = '0;
				reload_of[i] = '0;
				countdown_of[i] = 0;
			end
			ticks_off = 1'b0;
			uptime_now = '0;
			tick_us = TICK_PERIOD_RST;
			step_ms = UPTIME_STEP_RST;
			expected_beats.delete();
			queued <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TICK_PERIOD: tick_us = cfg_data[PERIOD_W-1:0];
					REG_UPTIME_STEP: step_ms = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				run_timer_command(cmd, rate_ms, handler_tag, timer_id);
			end
			if (result_valid) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: beat with none expected, actual kind %0h slot %0h handler %0h",
						$time, kind, slot_number, fired_handler);
					failures++;
				end else begin
					want = expected_beats.pop_front();
					bad = field_differs("kind", 32'(want.kind), 32'(kind))
						+ field_differs("slot_number", 32'(want.slot_number), 32'(slot_number))
						+ field_differs("fired_handler", want.fired_handler, fired_handler)
						+ field_differs("ok", 32'(want.ok), 32'(ok))
						+ field_differs("uptime_ms", want.uptime_ms, uptime_ms)
						+ field_differs("last", 32'(want.last), 32'(last));
					if (bad != 0) begin
						failures++;
					end
				end
			end
			queued <= expected_beats.size();
		end
	end

endmodule

// ===== verif/periodic_timer_slot_bank_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_slot_bank_test
// Drives the timer slot bank with a directed opening and then random command
// streams. The streams run under several tick period and uptime step settings,
// with the period register at zero, one and its largest value among them.
// The checker beside the block predicts and compares; this module makes the
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module periodic_timer_slot_bank_test;
	import ptsb_pkg::*;

	localparam int NUM_SLOTS      = 8;
	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = NUM_SLOTS + 8;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [2:0]       CMD_SPARE_LO    = 3'd6;
	localparam logic [2:0]       CMD_SPARE_HI    = 3'd7;
	localparam logic [CFG_W-1:0] TICK_PERIOD_MAX = 20'd1000000;
	localparam logic [CFG_W-1:0] UPTIME_STEP_MAX = 20'd1000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        cmd;
	logic [15:0]       rate_ms;
	logic [31:0]       handler_tag;
	logic [15:0]       timer_id;
	logic              result_valid;
	logic [1:0]        kind;
	logic [3:0]        slot_number;
	logic [31:0]       fired_handler;
	logic              ok;
	logic [31:0]       uptime_ms;
	logic              last;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	int                fail_count;
	int                beats_pending;
	bit                steady = 1'b0;

	always #1 clk = ~clk;

	periodic_timer_slot_bank #(.NUM_SLOTS(NUM_SLOTS)) u_dut (.*);

	periodic_timer_slot_bank_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (.*);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Mostly short periods so that slots fire often; now and then the full range.
	function automatic logic [15:0] pick_rate();
		int r;
		r = $urandom_range(0, 7);
		if (r < 2) begin
			return '0;
		end
		if (r == 2) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(1, 300));
	endfunction

	task automatic send_cmd(input logic [2:0] code, input logic [15:0] rate,
			input logic [31:0] tag, input logic [15:0] id);
		int gap;
		cmd <= code;
		rate_ms <= rate;
		handler_tag <= tag;
		timer_id <= id;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic [2:0]  code;
		logic [15:0] rate;
		logic [15:0] id;
		logic [31:0] tag;
		int          r;
		r = $urandom_range(0, 99);
		rate = 16'($urandom);
		tag = $urandom;
		id = 16'($urandom);
		if (r < 25) begin
			code = CMD_CREATE;
			rate = pick_rate();
			if ($urandom_range(0, 9) == 0) begin
				tag = '0;
			end
		end else if (r < 45) begin
			code = CMD_KILL;
			if ($urandom_range(0, 4) != 0) begin
				id = 16'($urandom_range(1, NUM_SLOTS));
			end
		end else if (r < 85) begin
			code = CMD_TICK;
		end else begin
			code = 3'($urandom_range(CMD_ENABLE, CMD_SPARE_HI));
		end
		send_cmd(code, rate, tag, id);
	endtask

	// Holds the sender off until every expected beat has come and the bank is idle.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (beats_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [CFG_W-1:0] period_us, input logic [CFG_W-1:0] step);
		write_reg(REG_TICK_PERIOD, period_us);
		write_reg(REG_UPTIME_STEP, step);
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_UPTIME;
		rate_ms <= '0;
		handler_tag <= '0;
		timer_id <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_TICK_PERIOD;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(CMD_UPTIME, '0, '0, '0);
		send_cmd(CMD_CREATE, 16'd100, 32'h0, '0);
		send_cmd(CMD_CREATE, 16'hFFFF, 32'hFFFF_FFFF, '0);
		send_cmd(CMD_CREATE, 16'd0, 32'h1, '0);
		send_cmd(CMD_CREATE, 16'd1, 32'hA000_0003, '0);
		send_cmd(CMD_CREATE, 16'd55, 32'hA000_0004, '0);
		send_cmd(CMD_CREATE, 16'd100, 32'hA000_0005, '0);
		send_cmd(CMD_CREATE, 16'd2, 32'hA000_0006, '0);
		send_cmd(CMD_CREATE, 16'h8000, 32'hA000_0007, '0);
		send_cmd(CMD_CREATE, 16'd54, 32'hA000_0008, '0);
		// The bank is full now, so this one must be refused.
		send_cmd(CMD_CREATE, 16'd10, 32'h1234_5678, '0);
		send_cmd(CMD_KILL, '0, '0, 16'd0);
		send_cmd(CMD_KILL, '0, '0, 16'd9);
		send_cmd(CMD_KILL, '0, '0, 16'hFFFF);
		send_cmd(CMD_KILL, '0, '0, 16'd3);
		send_cmd(CMD_KILL, '0, '0, 16'd3);
		send_cmd(CMD_TICK, '0, '0, '0);
		send_cmd(CMD_DISABLE, '0, '0, '0);
		send_cmd(CMD_TICK, '0, '0, '0);
		send_cmd(CMD_ENABLE, '0, '0, '0);
		send_cmd(CMD_TICK, '0, '0, '0);
		send_cmd(CMD_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_cmd(CMD_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_cmd(CMD_CREATE, 16'd30, 32'hC0DE_0003, '0);
		send_cmd(CMD_TICK, '0, '0, '0);
		wait_drained();

		set_timing(20'd20000, UPTIME_STEP_MAX);
		repeat (12) send_random();
		wait_drained();

		set_timing(20'd1, 20'd0);
		repeat (8) send_random();
		// Refill half the bank with one-microsecond periods. Under the longest
		// tick period their countdowns then sink until they reach the floor.
		for (int k = 1; k <= NUM_SLOTS; k++) begin
			send_cmd(CMD_KILL, '0, '0, 16'(k));
		end
		for (int k = 0; k < 4; k++) begin
			send_cmd(CMD_CREATE, '0, 32'h5A00_0001 + 32'(k), '0);
		end
		wait_drained();

		set_timing(TICK_PERIOD_MAX, 20'd1);
		send_cmd(CMD_ENABLE, '0, '0, '0);
		steady = 1'b1;
		repeat (140) send_cmd(CMD_TICK, 16'($urandom), $urandom, 16'($urandom));
		steady = 1'b0;
		repeat (8) send_random();
		wait_drained();

		// A zero tick period makes every slot created under it with a zero rate fire on each tick.
		set_timing(20'd0, UPTIME_STEP_MAX);
		send_cmd(CMD_ENABLE, '0, '0, '0);
		repeat (8) send_random();
		wait_drained();

		set_timing(CFG_W'(TICK_PERIOD_RST), CFG_W'(UPTIME_STEP_RST));
		repeat (6) send_random();
		steady = 1'b1;
		repeat (6) send_random();
		steady = 1'b0;
		wait_drained();

		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Ends the run when no beat has moved on any port for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || result_valid || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ptsb_pkg.sv
sv/periodic_timer_slot_bank.sv
verif/periodic_timer_slot_bank_checker.sv
verif/periodic_timer_slot_bank_test.sv
